>>> hw/rtl/ccl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared constants, register indexes and record type for the labeler.
// ----------------------------------------------------------------------------
package ccl_pkg;
  localparam int MaxCols = 64;
  localparam int MaxRows = 64;
  localparam int MaxComponents = 64;
  localparam int PixCap = MaxCols * MaxRows;
  localparam int AddrW = $clog2(PixCap);
  localparam int ColW = $clog2(MaxCols);
  localparam int RowW = $clog2(MaxRows);
  localparam int RecW = $clog2(MaxComponents);

  localparam logic [1:0] RegConn = 2'd0;
  localparam logic [1:0] RegCols = 2'd1;
  localparam logic [1:0] RegRows = 2'd2;

  typedef struct packed {
    logic [12:0]     size;
    logic [ColW-1:0] left;
    logic [RowW-1:0] top;
    logic [ColW-1:0] right;
    logic [RowW-1:0] bottom;
  } rec_t;

  // Column and row steps of the eight neighbours; the first four form the
  // four-neighbour set.
  function automatic logic signed [1:0] nb_dc(input logic [2:0] k);
    unique case (k)
      3'd0: nb_dc = -2'sd1;
      3'd1: nb_dc = 2'sd1;
      3'd2: nb_dc = 2'sd0;
      3'd3: nb_dc = 2'sd0;
      3'd4: nb_dc = -2'sd1;
      3'd5: nb_dc = -2'sd1;
      3'd6: nb_dc = 2'sd1;
      default: nb_dc = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] nb_dr(input logic [2:0] k);
    unique case (k)
      3'd0: nb_dr = 2'sd0;
      3'd1: nb_dr = 2'sd0;
      3'd2: nb_dr = -2'sd1;
      3'd3: nb_dr = 2'sd1;
      3'd4: nb_dr = -2'sd1;
      3'd5: nb_dr = 2'sd1;
      3'd6: nb_dr = -2'sd1;
      default: nb_dr = 2'sd1;
    endcase
  endfunction
endpackage

>>> hw/rtl/connected_component_labeler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connected_component_labeler
// Loads a binary frame, flood-fills its components and emits their records.
// ----------------------------------------------------------------------------
// Usage: write connectivity, columns and rows through the cfg channel while
// no frame is in flight; cfg_ready is high only while idle or loading pixels.
// Pulse start with one pixel per word; busy stays low while the frame loads,
// so pixels may follow back to back, one a cycle. The frame's last pixel
// begins processing and raises busy: a clearing pass over the whole visited
// map (one entry a cycle), then a raster scan of the frame's pixels. Each
// fill pops one pixel and tests its neighbours one at a time through a
// single neighbour unit and memory port: a pop reads the stack (S_POP, then
// S_PRD), each neighbour is requested in S_NRQ and checked in S_NCHK, and
// an empty stack closes the component in S_REC. Records then leave one
// per cycle on the result ports, marked by strobe, last_record set on the
// final one; an empty frame gives one record with valid_res low. The receiver
// cannot stall: each record lives one cycle. busy drops in the cycle that
// carries the last record.
// Reset clears control state and restores register defaults (seven-bit
// sizes of 64, four-neighbour mode); pixel and record memories hold no reset.
// ----------------------------------------------------------------------------
module connected_component_labeler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        foreground,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        strobe,
  output logic        valid_res,
  output logic [5:0]  comp_index,
  output logic [12:0] pixel_total,
  output logic [5:0]  box_left,
  output logic [5:0]  box_top,
  output logic [6:0]  box_cols,
  output logic [6:0]  box_rows,
  output logic [11:0] components_found,
  output logic        dropped,
  output logic        last_record
);
  import ccl_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_NRQ   = 4'd6;
  localparam logic [3:0] S_NCHK  = 4'd7;
  localparam logic [3:0] S_REC   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_EMPTY = 4'd10;

  logic [3:0] state;
  logic conn;
  logic [6:0] cols_reg, rows_reg;
  logic [ColW:0] cols;
  logic [RowW:0] rows;
  logic [AddrW:0] total;

  // Clamp the size registers: zero reads as one, above the maximum as it.
  always_comb begin
    cols = (cols_reg == 7'd0) ? (ColW+1)'(1) :
           (cols_reg > 7'(MaxCols)) ? (ColW+1)'(MaxCols) : (ColW+1)'(cols_reg);
    rows = (rows_reg == 7'd0) ? (RowW+1)'(1) :
           (rows_reg > 7'(MaxRows)) ? (RowW+1)'(MaxRows) : (RowW+1)'(rows_reg);
    total = (AddrW+1)'(cols) * (AddrW+1)'(rows);
  end

  // Hold off register writes while a frame is being processed or emitted.
  assign cfg_ready = (state == S_LOAD);
  always_ff @(posedge clk) begin
    if (rst) begin
      conn <= 1'b0;
      cols_reg <= 7'd64;
      rows_reg <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegConn: conn <= cfg_data[0];
        RegCols: cols_reg <= cfg_data;
        RegRows: rows_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memories: frame pixels, visited marks, records.
  logic frame_mem [PixCap];
  logic vis_mem [PixCap];
  rec_t rec_mem [MaxComponents];
  logic fr_q, vis_q;
  rec_t rec_q;

  logic [AddrW:0] load_pos;
  logic [AddrW:0] pos;           // clear and scan position
  logic [AddrW:0] sp;            // stack depth
  logic [ColW-1:0] pc;
  logic [RowW-1:0] pr;
  logic [2:0] k;
  logic [ColW-1:0] minc, maxc;
  logic [RowW-1:0] minr, maxr;
  logic [12:0] csize;
  logic [11:0] ccount;
  logic [RecW:0] stored;
  logic [RecW:0] emit_i;
  logic emit_v;

  logic nb_in;
  logic [ColW-1:0] nbc;
  logic [RowW-1:0] nbr;
  logic [AddrW-1:0] nb_addr;
  logic [AddrW-1:0] nb_hold;
  logic nb_ok;

  logic [ColW-1:0] scan_c, hc;
  logic [RowW-1:0] scan_r, hr;
  logic [2:0] nmax;
  assign nmax = conn ? 3'd7 : 3'd3;

  ccl_nbr_unit u_nbr (
    .col(pc), .row(pr), .k(k), .cols(cols), .rows(rows),
    .inside_frame(nb_in), .ncol(nbc), .nrow(nbr), .addr(nb_addr)
  );

  // Address of the pixel under test: scan position or the neighbour unit's address.
  logic [AddrW-1:0] rd_addr;
  always_comb begin
    rd_addr = (state == S_SCAN) ? pos[AddrW-1:0] : nb_addr;
  end

  logic start_acc;
  assign start_acc = start && !busy;
  assign busy = (state != S_LOAD);

  logic frame_done;
  assign frame_done = (load_pos + 1'b1) >= total;

  always_ff @(posedge clk) begin
    if (start_acc && load_pos < (AddrW+1)'(PixCap))
      frame_mem[load_pos[AddrW-1:0]] <= foreground;
    fr_q <= frame_mem[rd_addr];
    vis_q <= vis_mem[rd_addr];
    rec_q <= rec_mem[emit_i[RecW-1:0]];
    if (state == S_CLR) vis_mem[pos[AddrW-1:0]] <= 1'b0;
    if (state == S_SRD && fr_q && !vis_q)
      vis_mem[pos[AddrW-1:0]] <= 1'b1;
    if (state == S_NCHK && nb_ok && fr_q && !vis_q)
      vis_mem[nb_hold] <= 1'b1;
    if (state == S_REC && stored < (RecW+1)'(MaxComponents))
      rec_mem[stored[RecW-1:0]] <= '{csize, minc, minr, maxc, maxr};
  end

  // Fill stack: each word holds the column and row of a pushed pixel, so a
  // pop needs no divide to split an address.
  logic [ColW+RowW-1:0] crd_mem [PixCap];
  logic [ColW+RowW-1:0] crd_q;
  always_ff @(posedge clk) begin
    crd_q <= crd_mem[sp[AddrW-1:0] - 1'b1];
    if (state == S_SRD && fr_q && !vis_q)
      crd_mem[0] <= {scan_c, scan_r};
    if (state == S_NCHK && nb_ok && fr_q && !vis_q)
      crd_mem[sp[AddrW-1:0]] <= {hc, hr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      load_pos <= '0;
      pos <= '0;
      sp <= '0;
      k <= '0;
      ccount <= '0;
      stored <= '0;
      emit_i <= '0;
      emit_v <= 1'b0;
      scan_c <= '0;
      scan_r <= '0;
      nb_ok <= 1'b0;
    end else begin
      emit_v <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (start_acc) begin
            if (frame_done) begin
              load_pos <= '0;
              pos <= '0;
              state <= S_CLR;
            end else begin
              load_pos <= load_pos + 1'b1;
            end
          end
        end
        S_CLR: begin
          // Sweep the visited map once per frame.
          if (pos == (AddrW+1)'(PixCap - 1)) begin
            pos <= '0;
            scan_c <= '0;
            scan_r <= '0;
            ccount <= '0;
            stored <= '0;
            state <= S_SCAN;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_SCAN: begin
          if (pos >= total) begin
            emit_i <= '0;
            state <= (stored == '0) ? S_EMPTY : S_EMIT;
          end else begin
            state <= S_SRD;
          end
        end
        S_SRD: begin
          if (fr_q && !vis_q) begin
            sp <= (AddrW+1)'(1);
            minc <= '1; minr <= '1; maxc <= '0; maxr <= '0;
            csize <= '0;
            state <= S_POP;
          end else begin
            state <= S_SCAN;
          end
          pos <= pos + 1'b1;
          if ((ColW+1)'(scan_c) + 1'b1 == cols) begin
            scan_c <= '0;
            scan_r <= scan_r + 1'b1;
          end else begin
            scan_c <= scan_c + 1'b1;
          end
        end
        S_POP: begin
          if (sp == '0) state <= S_REC;
          else state <= S_PRD;
        end
        S_PRD: begin
          // Stack read data now valid: take the pixel, fold it in.
          {pc, pr} <= crd_q;
          sp <= sp - 1'b1;
          if (csize != 13'h1FFF) csize <= csize + 1'b1;
          if (crd_q[ColW+RowW-1:RowW] < minc) minc <= crd_q[ColW+RowW-1:RowW];
          if (crd_q[ColW+RowW-1:RowW] > maxc) maxc <= crd_q[ColW+RowW-1:RowW];
          if (crd_q[RowW-1:0] < minr) minr <= crd_q[RowW-1:0];
          if (crd_q[RowW-1:0] > maxr) maxr <= crd_q[RowW-1:0];
          k <= '0;
          state <= S_NRQ;
        end
        S_NRQ: begin
          nb_ok <= nb_in;
          nb_hold <= nb_addr;
          hc <= nbc;
          hr <= nbr;
          state <= S_NCHK;
        end
        S_NCHK: begin
          if (nb_ok && fr_q && !vis_q) sp <= sp + 1'b1;
          if (k == nmax) begin
            state <= S_POP;
          end else begin
            k <= k + 1'b1;
            state <= S_NRQ;
          end
        end
        S_REC: begin
          if (stored < (RecW+1)'(MaxComponents)) stored <= stored + 1'b1;
          if (ccount != 12'hFFF) ccount <= ccount + 1'b1;
          state <= S_SCAN;
        end
        S_EMIT: begin
          // Registered read: record emit_i appears on the ports in the next cycle.
          emit_v <= 1'b1;
          emit_i <= emit_i + 1'b1;
          if (emit_i + 1'b1 == stored) state <= S_LOAD;
        end
        S_EMPTY: begin
          emit_v <= 1'b1;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Output stage: one record per strobe.
  logic [RecW:0] out_i;
  logic out_empty;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_i <= '0;
      out_empty <= 1'b0;
    end else begin
      out_i <= emit_i;
      out_empty <= (state == S_EMPTY);
    end
  end

  assign strobe = emit_v;
  always_comb begin
    if (out_empty) begin
      valid_res = 1'b0; comp_index = '0; pixel_total = '0; box_left = '0;
      box_top = '0; box_cols = '0; box_rows = '0; components_found = '0;
      dropped = 1'b0; last_record = 1'b1;
    end else begin
      valid_res = 1'b1;
      comp_index = 6'(out_i);
      pixel_total = rec_q.size;
      box_left = 6'(rec_q.left);
      box_top = 6'(rec_q.top);
      box_cols = 7'((ColW+1)'(rec_q.right) - (ColW+1)'(rec_q.left) + 1'b1);
      box_rows = 7'((RowW+1)'(rec_q.bottom) - (RowW+1)'(rec_q.top) + 1'b1);
      components_found = ccount;
      dropped = ccount > 12'(MaxComponents);
      last_record = (out_i + 1'b1 == stored);
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= (AddrW+1)'(PixCap)) else $error("stack overflow");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && !$past(state == S_EMIT || state == S_EMPTY)) |-> !strobe)
    else $error("strobe while idle");
  a_stored_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= (RecW+1)'(MaxComponents)) else $error("record overflow");
endmodule

>>> hw/rtl/ccl_nbr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_nbr_unit
// Shared neighbour unit: steps one coordinate pair, bounds check, address.
// ----------------------------------------------------------------------------
module ccl_nbr_unit (
  input  logic [ccl_pkg::ColW-1:0]  col,
  input  logic [ccl_pkg::RowW-1:0]  row,
  input  logic [2:0]                k,
  input  logic [ccl_pkg::ColW:0]    cols,
  input  logic [ccl_pkg::RowW:0]    rows,
  output logic                      inside_frame,
  output logic [ccl_pkg::ColW-1:0]  ncol,
  output logic [ccl_pkg::RowW-1:0]  nrow,
  output logic [ccl_pkg::AddrW-1:0] addr
);
  import ccl_pkg::*;
  logic signed [ColW+1:0] c2;
  logic signed [RowW+1:0] r2;
  always_comb begin
    c2 = $signed({2'b00, col}) + (ColW+2)'(nb_dc(k));
    r2 = $signed({2'b00, row}) + (RowW+2)'(nb_dr(k));
    inside_frame = (c2 >= 0) && (r2 >= 0) && (c2 < $signed({1'b0, cols}))
                   && (r2 < $signed({1'b0, rows}));
    ncol = c2[ColW-1:0];
    nrow = r2[RowW-1:0];
    addr = AddrW'(nrow * cols) + AddrW'(ncol);
  end
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the connected component labeler.
// ----------------------------------------------------------------------------
// Frames are loaded one pixel per word through the start/busy handshake. The
// sender works in bursts with random gaps between them. A short directed
// table covers the clamping of zero and out-of-range sizes, the widest box,
// empty and single-pixel frames, both connectivities, and a frame with more
// components than the record store holds. Random small frames with random
// density and connectivity follow.
// Every record on the result ports is checked against an in-bench flood-fill
// labeller, or against a record built by hand where the table marks it obvious.
// ----------------------------------------------------------------------------
module tb_top;
  import ccl_pkg::*;

  typedef enum logic [1:0] {PatZero, PatOne, PatChecker, PatRandom} pattern_e;

  typedef struct packed {
    logic        valid_res;
    logic [5:0]  comp_index;
    logic [12:0] pixel_total;
    logic [5:0]  box_left;
    logic [5:0]  box_top;
    logic [6:0]  box_cols;
    logic [6:0]  box_rows;
    logic [11:0] components_found;
    logic        dropped;
    logic        last_record;
  } comp_record_t;

  typedef struct {
    logic     conn;
    logic [6:0] cols_raw;
    logic [6:0] rows_raw;
    pattern_e pat;
    bit       typed;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        foreground = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = RegConn;
  logic [6:0]  cfg_data = '0;
  logic        strobe;
  comp_record_t got;

  connected_component_labeler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .foreground(foreground),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .strobe(strobe), .valid_res(got.valid_res),
    .comp_index(got.comp_index), .pixel_total(got.pixel_total),
    .box_left(got.box_left), .box_top(got.box_top), .box_cols(got.box_cols),
    .box_rows(got.box_rows), .components_found(got.components_found),
    .dropped(got.dropped), .last_record(got.last_record)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Records still owed by the block, oldest first.
  comp_record_t pending_records[$];
  int           errors = 0;
  int           records_seen = 0;
  int           frames_sent = 0;
  int           pixels_sent = 0;
  int           burst_left = 0;

  // Pixels of the frame being loaded, and the settings it is loaded under.
  bit           frame_px[PixCap];
  logic         cur_conn;
  int           cur_cols;
  int           cur_rows;

  const int col_step[8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
  const int row_step[8] = '{0, 0, -1, 1, -1, 1, -1, 1};

  // Directed frames: sizes are raw register values, so zero and values above
  // the maximum exercise clamping.
  frame_row_t directed[8] = '{
    '{1'b0, 7'd1,   7'd1,  PatZero,    1'b1},  // lone background pixel
    '{1'b0, 7'd1,   7'd1,  PatOne,     1'b1},  // lone foreground pixel
    '{1'b1, 7'd0,   7'd0,  PatOne,     1'b1},  // zero sizes act as one
    '{1'b0, 7'd127, 7'd0,  PatOne,     1'b1},  // widest box, 64 by 1
    '{1'b1, 7'd3,   7'd3,  PatChecker, 1'b0},  // diagonals join in 8-mode
    '{1'b0, 7'd3,   7'd3,  PatChecker, 1'b0},  // ... but not in 4-mode
    '{1'b0, 7'd13,  7'd10, PatChecker, 1'b0},  // 65 components overflow the store
    '{1'b0, 7'd5,   7'd4,  PatRandom,  1'b0}
  };

  function automatic int clamp_size(logic [6:0] raw);
    if (raw == 0) return 1;
    if (raw > 64) return 64;
    return raw;
  endfunction

  // Append one record to the owed list.
  function automatic void queue_record(comp_record_t rec);
    pending_records.insert(pending_records.size(), rec);
  endfunction

  // Flood-fill the loaded frame and queue the records it should produce.
  function automatic void label_frame();
    bit           seen[PixCap];
    int           fill_stack[PixCap];
    comp_record_t recs[MaxComponents];
    comp_record_t rec;
    int depth, nrec;
    int total, found, nbrs, p, c, r, k, nc, nr, idx;
    int sz, minc, minr, maxc, maxr;
    total = cur_cols * cur_rows;
    found = 0;
    nrec = 0;
    depth = 0;
    nbrs = cur_conn ? 8 : 4;
    for (int s = 0; s < total; s++) begin
      if (seen[s] || !frame_px[s]) continue;
      seen[s] = 1'b1;
      fill_stack[depth] = s;
      depth++;
      sz = 0; minc = 4095; minr = 4095; maxc = 0; maxr = 0;
      while (depth > 0) begin
        depth--;
        p = fill_stack[depth];
        c = p % cur_cols;
        r = p / cur_cols;
        sz++;
        if (c < minc) minc = c;
        if (r < minr) minr = r;
        if (c > maxc) maxc = c;
        if (r > maxr) maxr = r;
        for (k = 0; k < nbrs; k++) begin
          nc = c + col_step[k];
          nr = r + row_step[k];
          if (nc < 0 || nr < 0 || nc >= cur_cols || nr >= cur_rows) continue;
          idx = nr * cur_cols + nc;
          if (seen[idx] || !frame_px[idx]) continue;
          seen[idx] = 1'b1;
          fill_stack[depth] = idx;
          depth++;
        end
      end
      if (nrec < MaxComponents) begin
        rec = '0;
        rec.valid_res = 1'b1;
        rec.comp_index = 6'(nrec);
        rec.pixel_total = (sz > 8191) ? 13'd8191 : 13'(sz);
        rec.box_left = 6'(minc);
        rec.box_top = 6'(minr);
        rec.box_cols = 7'(maxc - minc + 1);
        rec.box_rows = 7'(maxr - minr + 1);
        recs[nrec] = rec;
        nrec++;
      end
      if (found < 4095) found++;
    end
    if (nrec == 0) begin
      rec = '0;
      rec.last_record = 1'b1;
      queue_record(rec);
      return;
    end
    for (int i = 0; i < nrec; i++) begin
      rec = recs[i];
      rec.components_found = 12'(found);
      rec.dropped = (found > MaxComponents);
      rec.last_record = (i == nrec - 1);
      queue_record(rec);
    end
  endfunction

  // Write all three registers back to back; drop valid only after the last.
  task automatic write_settings(logic conn, logic [6:0] cols_raw, logic [6:0] rows_raw);
    logic [6:0] vals[3];
    logic [1:0] regs[3];
    vals = '{{6'd0, conn}, cols_raw, rows_raw};
    regs = '{RegConn, RegCols, RegRows};
    // Hold off until the previous frame has drained completely.
    while (pending_records.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_conn = conn;
    cur_cols = clamp_size(cols_raw);
    cur_rows = clamp_size(rows_raw);
  endtask

  // Send the frame held in frame_px, one word per pixel, in bursts.
  task automatic send_frame();
    int total;
    int gap;
    total = cur_cols * cur_rows;
    for (int i = 0; i < total; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      start      <= 1'b1;
      foreground <= frame_px[i];
      do @(posedge clk); while (busy);
      pixels_sent++;
    end
    start <= 1'b0;
    frames_sent++;
  endtask

  function automatic void build_frame(pattern_e pat, int density);
    for (int i = 0; i < cur_cols * cur_rows; i++) begin
      case (pat)
        PatZero:    frame_px[i] = 1'b0;
        PatOne:     frame_px[i] = 1'b1;
        PatChecker: frame_px[i] = ((i / cur_cols) + (i % cur_cols)) % 2 == 0;
        default:    frame_px[i] = ($urandom_range(0, 99) < density);
      endcase
    end
  endfunction

  // Check every record the moment it is strobed out.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      records_seen++;
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record %p", $realtime, got);
        errors++;
      end else begin
        comp_record_t want;
        want = pending_records.pop_front();
        if (got !== want) begin
          $display("%0t: record mismatch\n  expected %p\n  actual   %p",
                   $realtime, want, got);
          errors++;
        end
      end
    end
  end

  initial begin
    comp_record_t typed_rec;
    int random_pixels;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: typed records where they are obvious, else predicted.
    foreach (directed[i]) begin
      write_settings(directed[i].conn, directed[i].cols_raw, directed[i].rows_raw);
      build_frame(directed[i].pat, 50);
      if (directed[i].typed) begin
        typed_rec = '0;
        typed_rec.last_record = 1'b1;
        if (directed[i].pat == PatOne) begin
          typed_rec.valid_res = 1'b1;
          typed_rec.pixel_total = 13'(cur_cols * cur_rows);
          typed_rec.box_cols = 7'(cur_cols);
          typed_rec.box_rows = 7'(cur_rows);
          typed_rec.components_found = 12'd1;
        end
        queue_record(typed_rec);
      end else begin
        label_frame();
      end
      send_frame();
    end

    // Random small frames, occasionally with a zero size register.
    random_pixels = 0;
    while (random_pixels < 45) begin
      write_settings($urandom_range(0, 1),
                     ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 8)),
                     ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 8)));
      build_frame(PatRandom, $urandom_range(0, 100));
      label_frame();
      send_frame();
      random_pixels += cur_cols * cur_rows;
    end

    while (pending_records.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Run covered %0d frames, %0d pixels, %0d records checked.",
             frames_sent, pixels_sent, records_seen);
    if (errors == 0 && pending_records.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d records still owed.", pending_records.size());
    $display("*** FAILED ***");
    $finish;
  end
endmodule
